// ===== rtl/eib_pkg.sv =====
package eib_pkg;

    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;

    localparam int CoordW    = 6;
    localparam int ChanW     = 8;
    localparam int PixelW    = 4 * ChanW;
    localparam int AccW      = ChanW + 4;
    localparam int StrengthW = 5;
    localparam int CmdW      = 2;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 6;

    localparam logic [CoordW-1:0] RectRightReset  = CoordW'(63);
    localparam logic [CoordW-1:0] RectBottomReset = CoordW'(63);

    typedef enum logic [CmdW-1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RADIUS      = 3'd0,
        REG_ALPHA_ONLY  = 3'd1,
        REG_RECT_LEFT   = 3'd2,
        REG_RECT_TOP    = 3'd3,
        REG_RECT_RIGHT  = 3'd4,
        REG_RECT_BOTTOM = 3'd5
    } t_cfg_reg;

    localparam int StrengthEntries = 17;

    localparam logic [StrengthW-1:0] StrengthTab [StrengthEntries] = '{
        5'd14, 5'd10, 5'd8, 5'd6, 5'd5, 5'd5, 5'd4, 5'd3, 5'd3,
        5'd3, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2
    };

    // radius 0 copies (16), past the table end the weakest step (1)
    function automatic logic [StrengthW-1:0] strength(input logic [4:0] radius);
        logic [StrengthW-1:0] a;
        if (radius == 5'd0) begin
            a = 5'd16;
        end else if (radius > 5'(StrengthEntries)) begin
            a = 5'd1;
        end else begin
            a = StrengthTab[radius - 5'd1];
        end
        return a;
    endfunction

endpackage

// ===== rtl/exponential_image_blur.sv =====
// Exponential blur image buffer. Holds a MAX_HEIGHT x MAX_WIDTH image of
// premultiplied ARGB pixels in one single-port-write, registered-read memory.
// Load words are written as taken; read words pass the memory read register,
// then the output register. A run word sweeps the configured rectangle four
// times (down, right, up, left) through one shared per-channel update unit
// (subtract, 13x6 multiply, rounding shift, add). A line starts in LSTART and
// LINIT, loading its first pixel; each further pixel takes PRD, PFETCH, then
// one CALC step per channel, or for alpha alone in alpha-only mode. The done
// word is registered as the last line ends. Input is stalled while a read or
// run is in progress, and while a result waits in the output register and
// the consumer stalls. Configuration is always ready and must only be written
// while idle. Pixels never loaded read back as undefined.
module exponential_image_blur #(
    parameter int MAX_WIDTH  = eib_pkg::MaxWidth,
    parameter int MAX_HEIGHT = eib_pkg::MaxHeight
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eib_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [eib_pkg::CfgDataW-1:0]  i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [eib_pkg::CmdW-1:0]      i_cmd,
    input  logic [eib_pkg::CoordW-1:0]    i_pixel_row,
    input  logic [eib_pkg::CoordW-1:0]    i_pixel_col,
    input  logic [eib_pkg::ChanW-1:0]     i_in_alpha,
    input  logic [eib_pkg::ChanW-1:0]     i_in_red,
    input  logic [eib_pkg::ChanW-1:0]     i_in_green,
    input  logic [eib_pkg::ChanW-1:0]     i_in_blue,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_done,
    output logic [eib_pkg::CoordW-1:0]    o_out_row,
    output logic [eib_pkg::CoordW-1:0]    o_out_col,
    output logic [eib_pkg::ChanW-1:0]     o_out_alpha,
    output logic [eib_pkg::ChanW-1:0]     o_out_red,
    output logic [eib_pkg::ChanW-1:0]     o_out_green,
    output logic [eib_pkg::ChanW-1:0]     o_out_blue
);

    localparam int CW       = eib_pkg::CoordW;
    localparam int PW       = eib_pkg::PixelW;
    localparam int AccW     = eib_pkg::AccW;
    localparam int SW       = eib_pkg::StrengthW;
    localparam int Depth    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CoordMax = (1 << CW) - 1;
    localparam int LastColI = (MAX_WIDTH - 1 < CoordMax) ? MAX_WIDTH - 1 : CoordMax;
    localparam int LastRowI = (MAX_HEIGHT - 1 < CoordMax) ? MAX_HEIGHT - 1 : CoordMax;
    localparam logic [CW-1:0] LastCol = CW'(LastColI);
    localparam logic [CW-1:0] LastRow = CW'(LastRowI);
    localparam logic [AW-1:0] RowPitch = AW'(MAX_WIDTH);
    localparam int ProdW    = AccW + SW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDOUT,
        S_LSTART,
        S_LINIT,
        S_PRD,
        S_PFETCH,
        S_CALC
    } t_state;

    typedef struct packed {
        logic          vertical;
        logic [CW-1:0] cross_lo;
        logic [CW-1:0] cross_hi;
        logic [CW-1:0] start;
        logic [CW-1:0] stop;
    } t_span;

    function automatic t_span span_of(
        input logic [1:0]    pass,
        input logic [CW-1:0] l,
        input logic [CW-1:0] t,
        input logic [CW-1:0] r,
        input logic [CW-1:0] b
    );
        t_span s;
        logic [CW-1:0] a_lo;
        logic [CW-1:0] a_hi;
        s.vertical = ~pass[0];
        s.cross_lo = pass[0] ? t : l;
        s.cross_hi = pass[0] ? b : r;
        a_lo       = pass[0] ? l : t;
        a_hi       = pass[0] ? r : b;
        s.start    = pass[1] ? a_hi : a_lo;
        s.stop     = pass[1] ? a_lo : a_hi;
        return s;
    endfunction

    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
        return AW'(row) * RowPitch + AW'(col);
    endfunction

    // configuration
    logic [4:0]    r_radius;
    logic          r_alpha_only;
    logic [CW-1:0] r_rect_left;
    logic [CW-1:0] r_rect_top;
    logic [CW-1:0] r_rect_right;
    logic [CW-1:0] r_rect_bottom;

    // sequencer
    t_state          r_state;
    logic [1:0]      r_pass;
    logic [CW-1:0]   r_cross;
    logic [CW-1:0]   r_along;
    logic [1:0]      r_ch;
    logic [1:0]      r_ch_lo;
    logic [SW-1:0]   r_a;
    logic [CW-1:0]   r_left;
    logic [CW-1:0]   r_top;
    logic [CW-1:0]   r_right;
    logic [CW-1:0]   r_bottom;
    logic [AccW-1:0] r_acc [4];
    logic [PW-1:0]   r_px;
    logic [CW-1:0]   r_rd_row;
    logic [CW-1:0]   r_rd_col;
    logic            r_rd_inside;

    // output register
    logic          r_out_valid;
    logic          r_out_done;
    logic [CW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;
    logic [PW-1:0] r_out_px;

    // memory
    logic [PW-1:0] r_mem [Depth];
    logic [PW-1:0] r_mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [PW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          in_accept;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic [CW-1:0] eff_right;
    logic [CW-1:0] eff_bottom;
    logic          rect_empty;
    t_span         span;
    t_span         span_nx;
    logic [AW-1:0] sw_addr;
    logic [CW-1:0] along_step;
    logic          along_last;

    // end-of-line advance
    logic          n_fin;
    logic [1:0]    n_pass;
    logic [CW-1:0] n_cross;
    logic [CW-1:0] n_along;

    // shared channel update unit
    logic [7:0]              cur_chan;
    logic [AccW-1:0]         cur_acc;
    logic signed [AccW:0]    u_diff;
    logic signed [ProdW-1:0] u_prod;
    logic signed [ProdW-1:0] u_bias;
    logic signed [ProdW-1:0] u_quot;
    logic signed [ProdW-1:0] u_sum;
    logic [AccW-1:0]         n_acc;
    logic [PW-1:0]           n_px;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign in_accept   = i_valid && !o_stall;
    assign in_inside   = (i_pixel_row <= LastRow) && (i_pixel_col <= LastCol);
    assign in_addr     = pix_addr(i_pixel_row, i_pixel_col);

    assign eff_right  = (r_rect_right > LastCol) ? LastCol : r_rect_right;
    assign eff_bottom = (r_rect_bottom > LastRow) ? LastRow : r_rect_bottom;
    assign rect_empty = (r_rect_left > eff_right) || (r_rect_top > eff_bottom);

    assign span    = span_of(r_pass, r_left, r_top, r_right, r_bottom);
    assign span_nx = span_of(r_pass + 2'd1, r_left, r_top, r_right, r_bottom);
    assign sw_addr = span.vertical ? pix_addr(r_along, r_cross)
                                   : pix_addr(r_cross, r_along);
    assign along_step = r_pass[1] ? (r_along - CW'(1)) : (r_along + CW'(1));
    assign along_last = (r_along == span.stop);

    always_comb begin
        n_fin   = 1'b0;
        n_pass  = r_pass;
        n_cross = r_cross + CW'(1);
        n_along = span.start;
        if (r_cross == span.cross_hi) begin
            if (r_pass == 2'd3) begin
                n_fin   = 1'b1;
                n_pass  = 2'd0;
                n_cross = '0;
                n_along = '0;
            end else begin
                n_pass  = r_pass + 2'd1;
                n_cross = span_nx.cross_lo;
                n_along = span_nx.start;
            end
        end
    end

    assign cur_chan = r_px[{r_ch, 3'b000} +: 8];
    assign cur_acc  = r_acc[r_ch];
    assign u_diff   = $signed({1'b0, cur_chan, 4'b0000}) - $signed({1'b0, cur_acc});
    assign u_prod   = ProdW'(u_diff) * ProdW'($signed({1'b0, r_a}));
    assign u_bias   = u_prod + (u_prod[ProdW-1] ? ProdW'(15) : ProdW'(0));
    assign u_quot   = u_bias >>> 4;
    assign u_sum    = $signed({{(ProdW-AccW){1'b0}}, cur_acc}) + u_quot;
    assign n_acc    = u_sum[AccW-1:0];

    always_comb begin
        n_px = r_px;
        n_px[{r_ch, 3'b000} +: 8] = n_acc[AccW-1:4];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sw_addr;
        mem_wdata = n_px;
        if (r_state == S_IDLE) begin
            mem_we    = in_accept && (i_cmd == eib_pkg::CMD_LOAD) && in_inside;
            mem_waddr = in_addr;
            mem_wdata = {i_in_alpha, i_in_red, i_in_green, i_in_blue};
        end else if (r_state == S_CALC) begin
            mem_we    = (r_ch == 2'd3);
        end
    end

    assign mem_raddr = (r_state == S_IDLE) ? in_addr : sw_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= '0;
            r_alpha_only  <= 1'b0;
            r_rect_left   <= '0;
            r_rect_top    <= '0;
            r_rect_right  <= eib_pkg::RectRightReset;
            r_rect_bottom <= eib_pkg::RectBottomReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (eib_pkg::t_cfg_reg'(i_cfg_index))
                eib_pkg::REG_RADIUS:      r_radius      <= i_cfg_data[4:0];
                eib_pkg::REG_ALPHA_ONLY:  r_alpha_only  <= i_cfg_data[0];
                eib_pkg::REG_RECT_LEFT:   r_rect_left   <= i_cfg_data[CW-1:0];
                eib_pkg::REG_RECT_TOP:    r_rect_top    <= i_cfg_data[CW-1:0];
                eib_pkg::REG_RECT_RIGHT:  r_rect_right  <= i_cfg_data[CW-1:0];
                eib_pkg::REG_RECT_BOTTOM: r_rect_bottom <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_cross     <= '0;
            r_along     <= '0;
            r_ch        <= '0;
            r_acc       <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_cmd)
                            eib_pkg::CMD_READ: begin
                                r_rd_row    <= i_pixel_row;
                                r_rd_col    <= i_pixel_col;
                                r_rd_inside <= in_inside;
                                r_state     <= S_RDOUT;
                            end
                            eib_pkg::CMD_RUN: begin
                                if (rect_empty) begin
                                    r_out_valid <= 1'b1;
                                    r_out_done  <= 1'b1;
                                    r_out_row   <= '0;
                                    r_out_col   <= '0;
                                    r_out_px    <= '0;
                                end else begin
                                    r_left   <= r_rect_left;
                                    r_top    <= r_rect_top;
                                    r_right  <= eff_right;
                                    r_bottom <= eff_bottom;
                                    r_a      <= eib_pkg::strength(r_radius);
                                    r_ch_lo  <= r_alpha_only ? 2'd3 : 2'd0;
                                    r_pass   <= 2'd0;
                                    r_cross  <= r_rect_left;
                                    r_along  <= r_rect_top;
                                    r_state  <= S_LSTART;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDOUT: begin
                    r_out_valid <= 1'b1;
                    r_out_done  <= 1'b0;
                    r_out_row   <= r_rd_row;
                    r_out_col   <= r_rd_col;
                    r_out_px    <= r_rd_inside ? r_mem_q : '0;
                    r_state     <= S_IDLE;
                end
                S_LSTART: begin
                    r_state <= S_LINIT;
                end
                S_LINIT: begin
                    for (int i = 0; i < 4; i++) begin
                        r_acc[i] <= {r_mem_q[i*8 +: 8], 4'b0000};
                    end
                    if (along_last) begin
                        r_pass  <= n_pass;
                        r_cross <= n_cross;
                        r_along <= n_along;
                        r_state <= n_fin ? S_IDLE : S_LSTART;
                        if (n_fin) begin
                            r_out_valid <= 1'b1;
                            r_out_done  <= 1'b1;
                            r_out_row   <= '0;
                            r_out_col   <= '0;
                            r_out_px    <= '0;
                        end
                    end else begin
                        r_along <= along_step;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PFETCH;
                end
                S_PFETCH: begin
                    r_px    <= r_mem_q;
                    r_ch    <= r_ch_lo;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_acc[r_ch] <= n_acc;
                    r_px        <= n_px;
                    if (r_ch != 2'd3) begin
                        r_ch <= r_ch + 2'd1;
                    end else if (along_last) begin
                        r_pass  <= n_pass;
                        r_cross <= n_cross;
                        r_along <= n_along;
                        r_state <= n_fin ? S_IDLE : S_LSTART;
                        if (n_fin) begin
                            r_out_valid <= 1'b1;
                            r_out_done  <= 1'b1;
                            r_out_row   <= '0;
                            r_out_col   <= '0;
                            r_out_px    <= '0;
                        end
                    end else begin
                        r_along <= along_step;
                        r_state <= S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_is_done   = r_out_done;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_alpha = r_out_px[31:24];
    assign o_out_red   = r_out_px[23:16];
    assign o_out_green = r_out_px[15:8];
    assign o_out_blue  = r_out_px[7:0];

endmodule

// ===== rtl/eib_checker.sv =====
module eib_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [eib_pkg::CmdW-1:0]      i_cmd,
    input logic [eib_pkg::CoordW-1:0]    i_pixel_row,
    input logic [eib_pkg::CoordW-1:0]    i_pixel_col,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_is_done,
    input logic [eib_pkg::CoordW-1:0]    o_out_row,
    input logic [eib_pkg::CoordW-1:0]    o_out_col,
    input logic [eib_pkg::ChanW-1:0]     o_out_alpha,
    input logic [eib_pkg::ChanW-1:0]     o_out_red,
    input logic [eib_pkg::ChanW-1:0]     o_out_green,
    input logic [eib_pkg::ChanW-1:0]     o_out_blue
);

    // result word held under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_is_done, o_out_row, o_out_col,
                                        o_out_alpha, o_out_red, o_out_green,
                                        o_out_blue}))
        else $error("result word changed while stalled");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_done |-> (o_out_row == '0) && (o_out_col == '0) &&
                                 (o_out_alpha == '0) && (o_out_red == '0) &&
                                 (o_out_green == '0) && (o_out_blue == '0))
        else $error("done word carries data");

    // read answers through the memory and output registers, at the requested place
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == eib_pkg::CMD_READ) |->
            ##2 (o_valid && !o_is_done &&
                 (o_out_row == $past(i_pixel_row, 2)) &&
                 (o_out_col == $past(i_pixel_col, 2))))
        else $error("read word missing or misplaced");

endmodule

bind exponential_image_blur eib_checker u_eib_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_cmd       (i_cmd),
    .i_pixel_row (i_pixel_row),
    .i_pixel_col (i_pixel_col),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_is_done   (o_is_done),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_alpha (o_out_alpha),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
